// ===== hw/rtl/tcw_pkg.sv =====
`timescale 1ns / 1ps

package tcw_pkg;

  // Field widths fixed by the item format.
  localparam int ACTION_W = 2;
  localparam int CHAR_W   = 8;
  localparam int INDEX_W  = 11;
  localparam int CELL_W   = 16;
  localparam int COUNT_W  = 16;
  localparam int ATTR_W   = 8;

  // Default screen geometry.
  localparam int DEF_SCREEN_COLUMNS = 80;
  localparam int DEF_SCREEN_ROWS    = 25;

  // Character codes and constants.
  localparam logic [CHAR_W-1:0]  CHAR_NEWLINE = 8'd10;
  localparam logic [CHAR_W-1:0]  CHAR_RETURN  = 8'd13;
  localparam logic [CHAR_W-1:0]  CHAR_SPACE   = 8'h20;
  localparam logic [ATTR_W-1:0]  ATTR_RESET   = 8'h07;
  localparam logic [COUNT_W-1:0] COUNT_MAX    = 16'hFFFF;

  typedef enum logic [ACTION_W-1:0] {
    ACT_PUT   = 2'd0,
    ACT_CLEAR = 2'd1,
    ACT_SET   = 2'd2,
    ACT_READ  = 2'd3
  } action_t;

  typedef struct packed {
    action_t             action;
    logic [CHAR_W-1:0]   char_code;
    logic                end_of_string;
    logic [INDEX_W-1:0]  cursor_target;
    logic [INDEX_W-1:0]  read_index;
  } in_item_t;

  typedef struct packed {
    logic [INDEX_W-1:0]  cursor_position;
    logic                scrolled;
    logic [CELL_W-1:0]   cell_data;
    logic                string_done;
    logic [COUNT_W-1:0]  chars_in_string;
  } out_item_t;

endpackage

// ===== hw/rtl/tcw_cell_store.sv =====
`timescale 1ns / 1ps

module tcw_cell_store #(
  parameter int DEPTH = 2000,
  parameter int AW    = 11,
  parameter int DW    = 16
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hw/rtl/text_console_writer_core.sv =====
`timescale 1ns / 1ps

// Text console engine: a SCREEN_ROWS x SCREEN_COLUMNS store of 16-bit cells
// (attribute in bits 15..8, character in bits 7..0) in one single-port-write,
// registered-read memory, plus a cursor. Each accepted item gives exactly one
// result. Items are handled one at a time; the write port of the cell store
// sets the pace. A set-cursor splits the target by a reciprocal multiply,
// then a remainder; a put that scrolls and a clear walk the store one cell
// per cycle, for the scroll copy and the blanking. The next item is
// accepted the cycle after the result enters the output register, even if
// that result is still stalled there. The cell store has no reset; cells
// read back undefined until a put, clear or scroll has written them.
// text_attribute is written through the cfg port at any time the block is
// idle and is always ready.

module text_console_writer_core
  import tcw_pkg::*;
#(
  parameter int SCREEN_COLUMNS = DEF_SCREEN_COLUMNS,
  parameter int SCREEN_ROWS    = DEF_SCREEN_ROWS
) (
  input  logic              clk,
  input  logic              rst_n,

  input  logic              in_valid,
  output logic              in_stall,
  input  in_item_t          in_data,

  output logic              out_valid,
  input  logic              out_stall,
  output out_item_t         out_data,

  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [ATTR_W-1:0] cfg_data
);

  // Geometry derived at elaboration.
  localparam int CELLS = SCREEN_COLUMNS * SCREEN_ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = $clog2(SCREEN_COLUMNS);
  localparam int IW    = (AW + 1 > INDEX_W) ? AW + 1 : INDEX_W;
  // Reciprocal of the column count: exact quotient for any index below 2**AW.
  localparam int SH    = AW + CW;
  localparam int MW    = AW + 2;
  localparam int PW    = AW + MW;
  localparam int RECIP = ((1 << SH) + SCREEN_COLUMNS - 1) / SCREEN_COLUMNS;

  localparam logic [AW:0]   CELLS_X   = (AW + 1)'(CELLS);
  localparam logic [AW:0]   COLS_X    = (AW + 1)'(SCREEN_COLUMNS);
  localparam logic [AW-1:0] COLS_A    = AW'(SCREEN_COLUMNS);
  localparam logic [AW-1:0] LAST_CELL = AW'(CELLS - 1);
  localparam logic [AW-1:0] SPAN      = AW'(CELLS - SCREEN_COLUMNS);
  localparam logic [CW-1:0] COL_LAST  = CW'(SCREEN_COLUMNS - 1);
  localparam logic [IW-1:0] CELLS_I   = IW'(CELLS);
  localparam logic [MW-1:0] RECIP_V   = MW'(RECIP);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_READ   = 7'b0000010,
    S_DIV    = 7'b0000100,
    S_SPLIT  = 7'b0001000,
    S_SCROLL = 7'b0010000,
    S_CLEAR  = 7'b0100000,
    S_EMIT   = 7'b1000000
  } state_t;

  // Control state.
  state_t              state_r, state_nxt;
  logic [AW-1:0]       cursor_r, cursor_nxt;
  logic [CW-1:0]       col_r, col_nxt;
  logic [COUNT_W-1:0]  cnt_r, cnt_nxt;
  logic [ATTR_W-1:0]   attr_r, attr_nxt;
  logic                pend_valid_r, pend_valid_nxt;
  logic                out_valid_r, out_valid_nxt;

  // Working and payload registers.
  logic [AW-1:0]       sweep_r, sweep_nxt;
  logic [AW-1:0]       tgt_r, tgt_nxt;
  logic [AW-1:0]       q_r, q_nxt;
  logic                scrolled_r, scrolled_nxt;
  logic [CELL_W-1:0]   cell_r, cell_nxt;
  logic                done_r, done_nxt;
  logic [COUNT_W-1:0]  rep_r, rep_nxt;
  logic                rd_oob_r, rd_oob_nxt;
  logic [AW-1:0]       pend_addr_r, pend_addr_nxt;
  logic                pend_mem_r, pend_mem_nxt;
  out_item_t           out_data_r, out_data_nxt;

  // Memory port.
  logic                mem_wr_en;
  logic [AW-1:0]       mem_wr_addr;
  logic [CELL_W-1:0]   mem_wr_data;
  logic                mem_rd_en;
  logic [AW-1:0]       mem_rd_addr;
  logic [CELL_W-1:0]   mem_rd_data;

  // Combinational helpers.
  logic                accept;
  logic                put_plain;
  logic [CELL_W-1:0]   blank;
  logic [AW:0]         cur_x, row_base, put_pos, put_back;
  logic [CW-1:0]       put_col;
  logic                put_scroll;
  logic [COUNT_W-1:0]  cnt_inc;
  logic [IW-1:0]       tgt_ext, ridx_ext;
  logic [AW-1:0]       tgt_clamp;
  logic                ridx_oob;
  logic                in_span;
  logic [AW-1:0]       sweep_src;
  logic [PW-1:0]       prod, prod_sh;
  logic [AW-1:0]       q_cols, rem;
  logic                out_free;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || !out_stall;
  assign blank     = {attr_r, CHAR_SPACE};

  // Put: newline and carriage return work from the row start; the cursor
  // column is tracked alongside so no division is needed.
  assign cur_x    = {1'b0, cursor_r};
  assign row_base = cur_x - (AW + 1)'(col_r);
  assign put_plain = (in_data.char_code != CHAR_NEWLINE) &&
                     (in_data.char_code != CHAR_RETURN);

  always_comb begin
    priority if (in_data.char_code == CHAR_NEWLINE) begin
      put_pos = row_base + COLS_X;
      put_col = '0;
    end else if (in_data.char_code == CHAR_RETURN) begin
      put_pos = row_base;
      put_col = '0;
    end else begin
      put_pos = cur_x + (AW + 1)'(1);
      put_col = (col_r == COL_LAST) ? '0 : col_r + CW'(1);
    end
  end

  // Scroll once the new position reaches the cell count, never past it.
  assign put_scroll = (put_pos >= CELLS_X);
  assign put_back   = put_pos - COLS_X;
  assign cnt_inc    = (cnt_r == COUNT_MAX) ? cnt_r : cnt_r + COUNT_W'(1);

  // Clamp set-cursor target and range-check read index.
  assign tgt_ext   = IW'(in_data.cursor_target);
  assign tgt_clamp = (tgt_ext < CELLS_I) ? tgt_ext[AW-1:0] : LAST_CELL;
  assign ridx_ext  = IW'(in_data.read_index);
  assign ridx_oob  = (ridx_ext >= CELLS_I);

  // Scroll source: the cell one row below, while inside the copied span.
  assign in_span   = (sweep_r < SPAN);
  assign sweep_src = sweep_r + COLS_A;

  // Set-cursor column: quotient by reciprocal, then remainder.
  assign prod    = PW'(tgt_r) * PW'(RECIP_V);
  assign prod_sh = prod >> SH;
  assign q_cols  = q_r * COLS_A;
  assign rem     = tgt_r - q_cols;

  // Memory port steering. A pending sweep write never meets an accept.
  always_comb begin
    mem_wr_en   = 1'b0;
    mem_wr_addr = pend_addr_r;
    mem_wr_data = pend_mem_r ? mem_rd_data : blank;
    if (pend_valid_r) begin
      mem_wr_en = 1'b1;
    end else if (accept && in_data.action == ACT_PUT && put_plain) begin
      mem_wr_en   = 1'b1;
      mem_wr_addr = cursor_r;
      mem_wr_data = {attr_r, in_data.char_code};
    end
  end

  always_comb begin
    mem_rd_en   = 1'b0;
    mem_rd_addr = '0;
    if (accept && in_data.action == ACT_READ && !ridx_oob) begin
      mem_rd_en   = 1'b1;
      mem_rd_addr = ridx_ext[AW-1:0];
    end else if (state_r == S_SCROLL && in_span) begin
      mem_rd_en   = 1'b1;
      mem_rd_addr = sweep_src;
    end
  end

  tcw_cell_store #(
    .DEPTH (CELLS),
    .AW    (AW),
    .DW    (CELL_W)
  ) u_store (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  // Sequencer.
  always_comb begin
    state_nxt      = state_r;
    cursor_nxt     = cursor_r;
    col_nxt        = col_r;
    cnt_nxt        = cnt_r;
    attr_nxt       = attr_r;
    sweep_nxt      = sweep_r;
    tgt_nxt        = tgt_r;
    q_nxt          = q_r;
    scrolled_nxt   = scrolled_r;
    cell_nxt       = cell_r;
    done_nxt       = done_r;
    rep_nxt        = rep_r;
    rd_oob_nxt     = rd_oob_r;
    pend_valid_nxt = 1'b0;
    pend_addr_nxt  = sweep_r;
    pend_mem_nxt   = 1'b0;
    out_data_nxt   = out_data_r;
    out_valid_nxt  = out_valid_r && out_stall;

    if (cfg_valid) begin
      attr_nxt = cfg_data;
    end

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          scrolled_nxt = 1'b0;
          cell_nxt     = '0;
          done_nxt     = 1'b0;
          rep_nxt      = '0;
          unique case (in_data.action)
            ACT_PUT: begin
              col_nxt = put_col;
              if (put_scroll) begin
                // Land on the last row and walk the store to shift it up.
                cursor_nxt   = put_back[AW-1:0];
                scrolled_nxt = 1'b1;
                sweep_nxt    = '0;
                state_nxt    = S_SCROLL;
              end else begin
                cursor_nxt = put_pos[AW-1:0];
                state_nxt  = S_EMIT;
              end
              if (in_data.end_of_string) begin
                done_nxt = 1'b1;
                rep_nxt  = cnt_inc;
                cnt_nxt  = '0;
              end else begin
                cnt_nxt = cnt_inc;
              end
            end
            ACT_CLEAR: begin
              cursor_nxt = '0;
              col_nxt    = '0;
              sweep_nxt  = '0;
              state_nxt  = S_CLEAR;
            end
            ACT_SET: begin
              cursor_nxt = tgt_clamp;
              tgt_nxt    = tgt_clamp;
              state_nxt  = S_DIV;
            end
            ACT_READ: begin
              rd_oob_nxt = ridx_oob;
              state_nxt  = S_READ;
            end
            default: begin
              state_nxt = S_EMIT;
            end
          endcase
        end
      end
      S_READ: begin
        cell_nxt  = rd_oob_r ? '0 : mem_rd_data;
        state_nxt = S_EMIT;
      end
      S_DIV: begin
        q_nxt     = prod_sh[AW-1:0];
        state_nxt = S_SPLIT;
      end
      S_SPLIT: begin
        col_nxt   = rem[CW-1:0];
        state_nxt = S_EMIT;
      end
      S_SCROLL, S_CLEAR: begin
        // Queue one cell write per cycle: copied data goes through the pending write register.
        pend_valid_nxt = 1'b1;
        pend_mem_nxt   = (state_r == S_SCROLL) && in_span;
        sweep_nxt      = sweep_r + AW'(1);
        if (sweep_r == LAST_CELL) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_data_nxt.cursor_position = INDEX_W'(cursor_r);
          out_data_nxt.scrolled        = scrolled_r;
          out_data_nxt.cell_data       = cell_r;
          out_data_nxt.string_done     = done_r;
          out_data_nxt.chars_in_string = rep_r;
          out_valid_nxt                = 1'b1;
          state_nxt                    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cursor_r     <= '0;
      col_r        <= '0;
      cnt_r        <= '0;
      attr_r       <= ATTR_RESET;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cursor_r     <= cursor_nxt;
      col_r        <= col_nxt;
      cnt_r        <= cnt_nxt;
      attr_r       <= attr_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sweep_r     <= sweep_nxt;
    tgt_r       <= tgt_nxt;
    q_r         <= q_nxt;
    scrolled_r  <= scrolled_nxt;
    cell_r      <= cell_nxt;
    done_r      <= done_nxt;
    rep_r       <= rep_nxt;
    rd_oob_r    <= rd_oob_nxt;
    pend_addr_r <= pend_addr_nxt;
    pend_mem_r  <= pend_mem_nxt;
    out_data_r  <= out_data_nxt;
  end

  // A queued sweep write must never compete with a new item for the port.
  a_port_free: assert property (@(posedge clk) disable iff (!rst_n)
    pend_valid_r |-> in_stall)
    else $error("sweep write overlaps an accepted item");

  // Cursor and column stay on the screen.
  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cursor_r <= LAST_CELL) && (col_r <= COL_LAST))
    else $error("cursor left the screen");

  // After a scroll the cursor sits on the last row.
  a_scroll_row: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT && scrolled_r) |-> (cursor_r >= SPAN))
    else $error("cursor not on last row after scroll");

  // The set-cursor split recovers a column inside the row.
  a_split_col: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SPLIT) |-> (rem < COLS_A))
    else $error("reciprocal quotient off by one");

endmodule
